/* hdl/voxel_face_culling_mesher_unit_macros.svh */
// ---------------------------------------------------------------------------
// Voxel face culling mesher: assertion macros
// Shared property shapes for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULLING_MESHER_UNIT_MACROS_SVH
`define VOXEL_FACE_CULLING_MESHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define VFCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define VFCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/vfcm_pkg.sv */
// ---------------------------------------------------------------------------
// vfcm_pkg
// Grid geometry, field widths, command codes and shared types of the mesher.
// ---------------------------------------------------------------------------
package vfcm_pkg;

  // Grid geometry: interior LINE x LINE, one cell of padding on x and y
  localparam int LINE     = 16;
  localparam int DEPTH_Z  = 64;
  localparam int SECTIONS = 16;
  localparam int EXT      = LINE + 2;
  localparam int PLANE    = EXT * EXT;
  localparam int CELLS    = PLANE * DEPTH_Z;
  localparam int IDX_W    = $clog2(CELLS);

  // Field widths
  localparam int XY_W  = 5;
  localparam int Z_W   = 6;
  localparam int VAL_W = 5;
  localparam int THR_W = 6;
  localparam int SEC_W = 4;
  localparam int DIR_W = 3;
  localparam int FXY_W = 4;
  localparam int BV_W  = 19;
  localparam int NDIR  = 6;

  localparam int VERTS_PER_FACE = 4;
  localparam logic signed [THR_W-1:0] THR_RESET = THR_W'(10);

  // Commands
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_MESH  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Face directions
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd1;
  localparam logic [DIR_W-1:0] DIR_PY = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd3;
  localparam logic [DIR_W-1:0] DIR_PX = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NX = 3'd5;

  // Result kinds
  localparam logic KIND_FACE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    op_t              operation;
    logic [XY_W-1:0]  pos_x;
    logic [XY_W-1:0]  pos_y;
    logic [Z_W-1:0]   pos_z;
    logic [VAL_W-1:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [SEC_W-1:0] section;
    logic [DIR_W-1:0] direction;
    logic [FXY_W-1:0] face_x;
    logic [FXY_W-1:0] face_y;
    logic [Z_W-1:0]   face_z;
    logic [BV_W-1:0]  base_vertex;
    logic [VAL_W-1:0] voxel_value;
    logic [IDX_W-1:0] cell_index;
    logic             last;
  } out_item_t;

  // Request to the address unit
  typedef struct packed {
    logic             sel_nb;    // 1: base + neighbor offset, 0: flat index of coords
    logic             interior;  // coords are interior, shift by the padding
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic [Z_W-1:0]   z;
    logic [IDX_W-1:0] base;
    logic [DIR_W-1:0] dir;
  } addr_req_t;

  // Request to the grid memory
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] wdata;
  } grid_req_t;

endpackage

/* hdl/voxel_face_culling_mesher_unit.sv */
// ---------------------------------------------------------------------------
// voxel_face_culling_mesher_unit
// Voxel grid store with face-culling mesher, stream in and stream out.
// ---------------------------------------------------------------------------
// One command at a time: s_axis_tready is high only while the sequencer is
// idle. A write, a start pass or a mesh outside the interior passes through
// S_ADDR only; a read or a mesh of a non-solid cell also through S_RDOUT or
// S_CENTER, and a mesh of a solid cell through S_CENTER, S_SCAN and, when it has
// faces, S_EMIT; a stalled result side holds up S_EMIT and S_RDOUT. The single
// grid memory port sets the pace: the center cell and then one neighbor per
// cycle are read through it, and the shared address adder forms one neighbor
// address per cycle. A read of a cell that was never written returns undefined
// data. Faces carry their base vertex from a per-section counter that a start pass clears.
`include "voxel_face_culling_mesher_unit_macros.svh"

module voxel_face_culling_mesher_unit
  import vfcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // opaque_threshold register
  input  logic                    cfg_we,
  input  logic signed [THR_W-1:0] cfg_wdata,
  // commands
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [23:0]             s_axis_tdata,  // pos_x[4:0], pos_y[9:5], pos_z[15:10],
                                                 // cell_value[20:16], zero pad
  input  logic [1:0]              s_axis_tuser,  // operation[1:0]
  // results
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [63:0]             m_axis_tdata,  // section[3:0], direction[6:4],
                                                 // face_x[10:7], face_y[14:11],
                                                 // face_z[20:15], base_vertex[39:21],
                                                 // voxel_value[44:40], cell_index[59:45],
                                                 // zero pad
  output logic                    m_axis_tuser,  // kind
  output logic                    m_axis_tlast
);

  logic signed [THR_W-1:0] opaque_threshold;
  in_item_t                in_item;
  out_item_t               out_item;
  addr_req_t               areq;
  logic [IDX_W-1:0]        addr;
  grid_req_t               greq;
  logic [VAL_W-1:0]        rdata;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      opaque_threshold <= THR_RESET;
    end else if (cfg_we) begin
      opaque_threshold <= cfg_wdata;
    end
  end

  // Command unpacking
  always_comb begin
    in_item.operation  = op_t'(s_axis_tuser);
    in_item.pos_x      = s_axis_tdata[4:0];
    in_item.pos_y      = s_axis_tdata[9:5];
    in_item.pos_z      = s_axis_tdata[15:10];
    in_item.cell_value = s_axis_tdata[20:16];
  end

  vfcm_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .opaque_threshold (opaque_threshold),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .in_item          (in_item),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_item         (out_item),
    .areq             (areq),
    .addr             (addr),
    .greq             (greq),
    .rdata            (rdata)
  );

  vfcm_addr u_addr (
    .req  (areq),
    .addr (addr)
  );

  vfcm_grid u_grid (
    .clk   (clk),
    .req   (greq),
    .rdata (rdata)
  );

  // Result packing
  assign m_axis_tdata = {4'b0, out_item.cell_index, out_item.voxel_value,
                         out_item.base_vertex, out_item.face_z, out_item.face_y,
                         out_item.face_x, out_item.direction, out_item.section};
  assign m_axis_tuser = out_item.kind;
  assign m_axis_tlast = out_item.last;

  // Checks
  `VFCM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command accepted while a command is in work")
  `VFCM_ASSERT_NOW(a_open_face_busy, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "idle while faces of a mesh are still pending")
  `VFCM_ASSERT_NOW(a_face_dir, m_axis_tvalid && m_axis_tuser == KIND_FACE, m_axis_tdata[6:4] <= DIR_NX, "face direction out of range")
  `VFCM_ASSERT_NOW(a_base_aligned, m_axis_tvalid && m_axis_tuser == KIND_FACE, m_axis_tdata[22:21] == 2'b00, "base vertex not a multiple of four")

endmodule

/* hdl/vfcm_grid.sv */
// ---------------------------------------------------------------------------
// vfcm_grid
// Padded voxel grid storage: one port, write or registered read per cycle.
// ---------------------------------------------------------------------------
module vfcm_grid
  import vfcm_pkg::*;
(
  input  logic             clk,
  input  grid_req_t        req,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [CELLS];

  // Cell store and read-out
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

/* hdl/vfcm_addr.sv */
// ---------------------------------------------------------------------------
// vfcm_addr
// Shared address unit: flat index of a position, or a neighbor of a cell.
// ---------------------------------------------------------------------------
module vfcm_addr
  import vfcm_pkg::*;
(
  input  addr_req_t        req,
  output logic [IDX_W-1:0] addr
);

  localparam int IDX_SPAN = 1 << IDX_W;

  function automatic logic [IDX_W-1:0] nb_offset(input logic [DIR_W-1:0] dir);
    logic [IDX_W-1:0] off;
    case (dir)
      DIR_PZ:  off = IDX_W'(PLANE);
      DIR_NZ:  off = IDX_W'(IDX_SPAN - PLANE);
      DIR_PY:  off = IDX_W'(EXT);
      DIR_NY:  off = IDX_W'(IDX_SPAN - EXT);
      DIR_PX:  off = IDX_W'(1);
      DIR_NX:  off = IDX_W'(IDX_SPAN - 1);
      default: off = '0;
    endcase
    return off;
  endfunction

  logic [XY_W:0]    px;
  logic [XY_W:0]    py;
  logic [IDX_W-1:0] flat;

  // Interior positions sit one cell in from the padding
  assign px = {1'b0, req.x} + (XY_W+1)'(req.interior);
  assign py = {1'b0, req.y} + (XY_W+1)'(req.interior);

  assign flat = IDX_W'(px) + IDX_W'(py) * IDX_W'(EXT) + IDX_W'(req.z) * IDX_W'(PLANE);

  // Neighbor offsets wrap modulo the index width
  assign addr = req.sel_nb ? (req.base + nb_offset(req.dir)) : flat;

endmodule

/* hdl/vfcm_ctrl.sv */
// ---------------------------------------------------------------------------
// vfcm_ctrl
// Command sequencer: grid access, neighbor scan, section counters and the
// result register.
// ---------------------------------------------------------------------------
module vfcm_ctrl
  import vfcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [THR_W-1:0] opaque_threshold,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_item,
  output addr_req_t               areq,
  input  logic [IDX_W-1:0]        addr,
  output grid_req_t               greq,
  input  logic [VAL_W-1:0]        rdata
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADDR   = 6'b000010,
    S_CENTER = 6'b000100,
    S_SCAN   = 6'b001000,
    S_EMIT   = 6'b010000,
    S_RDOUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  // Command registers
  op_t              op_q;
  logic [XY_W-1:0]  x_q;
  logic [XY_W-1:0]  y_q;
  logic [Z_W-1:0]   z_q;
  logic [VAL_W-1:0] val_q;
  logic [IDX_W-1:0] idx_q;
  logic             in_range_q;
  logic [SEC_W-1:0] sec_q;
  logic [DIR_W-1:0] dir_q;
  logic [NDIR-1:0]  mask_q;
  logic [BV_W-1:0]  count [SECTIONS];

  logic                    pad_ok;
  logic                    mesh_ok;
  logic signed [VAL_W-1:0] cell_s;
  logic signed [THR_W-1:0] cell_ext;
  logic                    center_ok;
  logic [DIR_W-1:0]        rd_dir;
  logic                    hit;
  logic [NDIR-1:0]         mask_next;
  logic [DIR_W-1:0]        pick;
  logic [NDIR-1:0]         rest;
  logic                    out_free;
  logic                    out_load;

  function automatic logic z_edge(input logic [DIR_W-1:0] d, input logic [Z_W-1:0] z);
    return (d == DIR_PZ && z == Z_W'(DEPTH_Z - 1)) || (d == DIR_NZ && z == '0);
  endfunction

  // Position checks on the latched command
  assign pad_ok  = (int'(x_q) < EXT) && (int'(y_q) < EXT) && (int'(z_q) < DEPTH_Z);
  assign mesh_ok = (int'(x_q) < LINE) && (int'(y_q) < LINE) && (int'(z_q) < DEPTH_Z);

  // Cell type checks and the opacity compare
  assign cell_s    = signed'(rdata);
  assign cell_ext  = THR_W'(cell_s);
  assign center_ok = (cell_s > 0) && (int'(cell_s) <= SECTIONS);
  assign hit       = !z_edge(dir_q, z_q) && (cell_ext < opaque_threshold);
  assign mask_next = mask_q | (NDIR'(hit) << dir_q);

  // Lowest pending face goes out first
  always_comb begin
    pick = '0;
    for (int i = NDIR - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        pick = DIR_W'(i);
      end
    end
  end
  assign rest = mask_q & ~(NDIR'(1) << pick);

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = ((state == S_EMIT) || (state == S_RDOUT)) && out_free;
  assign rd_dir   = (state == S_CENTER) ? DIR_PZ : (dir_q + 3'd1);

  // Address unit request
  always_comb begin
    areq.sel_nb   = (state != S_ADDR);
    areq.interior = (op_q == OP_MESH);
    areq.x        = x_q;
    areq.y        = y_q;
    areq.z        = z_q;
    areq.base     = idx_q;
    areq.dir      = rd_dir;
  end

  // Grid access: one write or one read per cycle
  always_comb begin
    greq.we    = (state == S_ADDR) && (op_q == OP_WRITE) && pad_ok;
    greq.addr  = addr;
    greq.wdata = val_q;
    greq.re    = 1'b0;
    case (state)
      S_ADDR:   greq.re = (op_q == OP_READ && pad_ok) || (op_q == OP_MESH && mesh_ok);
      S_CENTER: greq.re = center_ok && !z_edge(DIR_PZ, z_q);
      S_SCAN:   greq.re = (dir_q != DIR_NX) && !z_edge(rd_dir, z_q);
      default:  greq.re = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_ADDR;
      S_ADDR: begin
        case (op_q)
          OP_READ: state_next = S_RDOUT;
          OP_MESH: state_next = mesh_ok ? S_CENTER : S_IDLE;
          default: state_next = S_IDLE;
        endcase
      end
      S_CENTER: state_next = center_ok ? S_SCAN : S_IDLE;
      S_SCAN: begin
        if (dir_q == DIR_NX) begin
          state_next = (mask_next != '0) ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT:   if (out_free && rest == '0) state_next = S_IDLE;
      S_RDOUT:  if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state, counters and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dir_q     <= '0;
      mask_q    <= '0;
      for (int i = 0; i < SECTIONS; i++) begin
        count[i] <= '0;
      end
    end else begin
      state <= state_next;
      // new result loads as the held one leaves
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ADDR: begin
          if (op_q == OP_START) begin
            for (int i = 0; i < SECTIONS; i++) begin
              count[i] <= '0;
            end
          end
        end
        S_CENTER: begin
          dir_q  <= DIR_PZ;
          mask_q <= '0;
        end
        S_SCAN: begin
          mask_q <= mask_next;
          dir_q  <= dir_q + 3'd1;
        end
        S_EMIT: begin
          if (out_free) begin
            mask_q       <= rest;
            count[sec_q] <= count[sec_q] + BV_W'(VERTS_PER_FACE);
          end
        end
        default: ;
      endcase
    end
  end

  // Command latch and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_q  <= in_item.operation;
          x_q   <= in_item.pos_x;
          y_q   <= in_item.pos_y;
          z_q   <= in_item.pos_z;
          val_q <= in_item.cell_value;
        end
      end
      S_ADDR: begin
        idx_q      <= addr;
        in_range_q <= pad_ok;
      end
      S_CENTER: begin
        sec_q <= SEC_W'(cell_s - 5'sd1);
      end
      S_EMIT: begin
        if (out_free) begin
          out_item.kind        <= KIND_FACE;
          out_item.section     <= sec_q;
          out_item.direction   <= pick;
          out_item.face_x      <= FXY_W'(x_q);
          out_item.face_y      <= FXY_W'(y_q);
          out_item.face_z      <= z_q;
          out_item.base_vertex <= count[sec_q];
          out_item.voxel_value <= '0;
          out_item.cell_index  <= '0;
          out_item.last        <= (rest == '0);
        end
      end
      S_RDOUT: begin
        if (out_free) begin
          out_item.kind        <= KIND_READ;
          out_item.section     <= '0;
          out_item.direction   <= '0;
          out_item.face_x      <= '0;
          out_item.face_y      <= '0;
          out_item.face_z      <= '0;
          out_item.base_vertex <= '0;
          out_item.voxel_value <= in_range_q ? rdata : '0;
          out_item.cell_index  <= in_range_q ? idx_q : '0;
          out_item.last        <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
